@@ rtl/mlsc_pkg.sv @@
// Shared types, constants and helper functions for the level-set curvature block.
package mlsc_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned SumW    = 64;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned AddrW   = 3;
  localparam logic [31:0] FloorReset = 32'd4295;

  // Register index, taken from byte address bit 2.
  localparam logic RegFloor = 1'b0;

  localparam logic [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};
  localparam logic [DataW-1:0] CurvMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] CurvMin = {1'b1, {(DataW-1){1'b0}}};

  // Gradient sums x, y, z and Hessian sums xx, yy, zz, xy, xz, yz.
  typedef struct packed {
    logic [2:0][SumW-1:0] grad;
    logic [5:0][SumW-1:0] hess;
  } sums_t;

  // One term of the curvature numerator.
  typedef struct packed {
    logic [1:0] ga;
    logic [1:0] gb;
    logic [2:0] hi;
    logic       dbl;
  } term_t;

  typedef enum logic [3:0] {
    FIN_IDLE,
    FIN_SQ,
    FIN_SQRT,
    FIN_MSET,
    FIN_DEN1,
    FIN_DEN2,
    FIN_T1,
    FIN_T2,
    FIN_NUMFIX,
    FIN_CHK,
    FIN_DIV,
    FIN_RES
  } fin_state_e;

  function automatic logic [SumW-1:0] sat_add64(input logic [SumW-1:0] a,
                                                input logic [SumW-1:0] b);
    logic [SumW:0] s;
    logic [SumW-1:0] r;
    s = {a[SumW-1], a} + {b[SumW-1], b};
    if (s[SumW] != s[SumW-1]) begin
      r = s[SumW] ? SumMin : SumMax;
    end else begin
      r = s[SumW-1:0];
    end
    return r;
  endfunction

  function automatic logic [SumW-1:0] mag64(input logic [SumW-1:0] v);
    return v[SumW-1] ? (~v + 64'd1) : v;
  endfunction

  function automatic term_t term_of(input logic [3:0] k);
    term_t t;
    case (k)
      4'd0:    t = '{ga: 2'd0, gb: 2'd0, hi: 3'd1, dbl: 1'b0};
      4'd1:    t = '{ga: 2'd0, gb: 2'd1, hi: 3'd3, dbl: 1'b1};
      4'd2:    t = '{ga: 2'd1, gb: 2'd1, hi: 3'd0, dbl: 1'b0};
      4'd3:    t = '{ga: 2'd0, gb: 2'd0, hi: 3'd2, dbl: 1'b0};
      4'd4:    t = '{ga: 2'd0, gb: 2'd2, hi: 3'd4, dbl: 1'b1};
      4'd5:    t = '{ga: 2'd2, gb: 2'd2, hi: 3'd0, dbl: 1'b0};
      4'd6:    t = '{ga: 2'd1, gb: 2'd1, hi: 3'd2, dbl: 1'b0};
      4'd7:    t = '{ga: 2'd1, gb: 2'd2, hi: 3'd5, dbl: 1'b1};
      4'd8:    t = '{ga: 2'd2, gb: 2'd2, hi: 3'd1, dbl: 1'b0};
      default: t = '{ga: 2'd0, gb: 2'd0, hi: 3'd0, dbl: 1'b0};
    endcase
    return t;
  endfunction

endpackage

@@ rtl/mlsc_if.sv @@
// Request and result channel interfaces of the level-set curvature block.
interface mlsc_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] phi_center;
  logic signed [31:0] phi_neighbor;
  logic signed [31:0] weight_dx;
  logic signed [31:0] weight_dy;
  logic signed [31:0] weight_dz;
  logic signed [31:0] weight_dxx;
  logic signed [31:0] weight_dyy;
  logic signed [31:0] weight_dzz;
  logic signed [31:0] weight_dxy;
  logic signed [31:0] weight_dxz;
  logic signed [31:0] weight_dyz;
  logic               last_neighbor;

  modport source (
    output valid, phi_center, phi_neighbor, weight_dx, weight_dy, weight_dz,
           weight_dxx, weight_dyy, weight_dzz, weight_dxy, weight_dxz, weight_dyz,
           last_neighbor,
    input  ready
  );
  modport sink (
    input  valid, phi_center, phi_neighbor, weight_dx, weight_dy, weight_dz,
           weight_dxx, weight_dyy, weight_dzz, weight_dxy, weight_dxz, weight_dyz,
           last_neighbor,
    output ready
  );
endinterface

interface mlsc_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] curvature;
  logic               saturated;

  modport source (output valid, curvature, saturated, input ready);
  modport sink (input valid, curvature, saturated, output ready);
endinterface

@@ rtl/meshless_level_set_curvature.sv @@
// Top level of the meshless level-set mean curvature block.
//
// One request per neighbor of a point carries the centre and neighbor level-set
// values and nine derivative weights. The front end takes one request per cycle
// and adds (centre - neighbor) * weight into three gradient and six Hessian sums
// (Q32.32, saturating); only the first MAX_NEIGHBORS requests of a point add in.
// The request with last_neighbor set closes the point: the sums are pushed into
// a two-entry queue and cleared. The back end works one point at a time with
// shift-add multiplies, a bitwise square root and a restoring divider over a
// 256-bit datapath. Nine numerator terms, of two shift-add multiplies each,
// make up most of the back end's work on a point. Neighbor requests keep
// flowing while the back end works, until two closed points wait in the queue.
// The result carries the curvature in signed Q16.16 and a flag set when it was
// clipped; a zero denominator gives zero. Register gradient_floor sits at byte
// address 0 and should be written only while the block is idle.
module meshless_level_set_curvature #(
  parameter int unsigned MAX_NEIGHBORS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  mlsc_req_if.sink                   req_i,
  mlsc_res_if.source                 res_o,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic [mlsc_pkg::AddrW-1:0] paddr_i,
  input  logic [31:0]                pwdata_i,
  output logic [31:0]                prdata_o,
  output logic                       pready_o
);

  logic [31:0]     floor_q;
  logic            push, pop, q_valid, front_busy;
  logic [1:0]      q_free;
  mlsc_pkg::sums_t push_sums, head_sums;

  // Configuration port: a single register, always ready.
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == mlsc_pkg::RegFloor) ? floor_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= mlsc_pkg::FloorReset;
    end else if (psel_i && penable_i && pwrite_i && paddr_i[2] == mlsc_pkg::RegFloor) begin
      floor_q <= pwdata_i;
    end
  end

  mlsc_accum #(
    .MAX_NEIGHBORS(MAX_NEIGHBORS)
  ) u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .free_i (q_free),
    .push_o (push),
    .sums_o (push_sums),
    .busy_o (front_busy)
  );

  mlsc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_sums),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (head_sums),
    .free_o  (q_free)
  );

  mlsc_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .data_i  (head_sums),
    .floor_i (floor_q),
    .pop_o   (pop),
    .res_o   (res_o)
  );

`ifndef SYNTHESIS
  // A clipped result sits at one of the two range limits.
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.saturated |->
      res_o.curvature == mlsc_pkg::CurvMax || res_o.curvature == mlsc_pkg::CurvMin)
    else $error("saturated result not at a range limit");

  // The front end only stalls when closed points are waiting.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> q_valid || front_busy)
    else $error("request stalled with an empty queue");

  // Retiring a point always loads the result register.
  a_pop_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> res_o.valid)
    else $error("point retired without a result");

  // No push may arrive when the queue is full.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> q_free != 2'd0 || pop)
    else $error("queue overflow");
`endif

endmodule

@@ rtl/mlsc_accum.sv @@
// Front end: takes neighbor requests and accumulates the derivative sums.
module mlsc_accum #(
  parameter int unsigned MAX_NEIGHBORS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mlsc_req_if.sink          req_i,
  input  logic [1:0]        free_i,
  output logic              push_o,
  output mlsc_pkg::sums_t   sums_o,
  output logic              busy_o
);

  localparam int unsigned CntW = $clog2(MAX_NEIGHBORS + 1);

  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               s1_valid_q, s1_last_q, s1_use_q;
  logic [8:0][63:0]   prod_q, prod_d;
  mlsc_pkg::sums_t    sums_q, sums_d;
  logic signed [32:0] diff;
  logic signed [31:0] wgt [9];
  logic signed [64:0] prod_full [9];
  logic               accept;

  assign busy_o       = s1_valid_q & s1_last_q;
  assign req_i.ready  = free_i > {1'b0, busy_o};
  assign accept       = req_i.valid & req_i.ready;

  always_comb begin
    wgt[0] = req_i.weight_dx;
    wgt[1] = req_i.weight_dy;
    wgt[2] = req_i.weight_dz;
    wgt[3] = req_i.weight_dxx;
    wgt[4] = req_i.weight_dyy;
    wgt[5] = req_i.weight_dzz;
    wgt[6] = req_i.weight_dxy;
    wgt[7] = req_i.weight_dxz;
    wgt[8] = req_i.weight_dyz;
    diff = $signed({req_i.phi_center[31], req_i.phi_center})
         - $signed({req_i.phi_neighbor[31], req_i.phi_neighbor});
    for (int i = 0; i < 9; i++) begin
      prod_full[i] = diff * wgt[i];
      prod_d[i]    = prod_full[i][63:0];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (req_i.last_neighbor) begin
        cnt_d = '0;
      end else if (cnt_q < CntW'(MAX_NEIGHBORS)) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  // Second stage: saturating accumulate, snapshot and clear on the last neighbor.
  always_comb begin
    sums_o = sums_q;
    if (s1_use_q) begin
      for (int i = 0; i < 3; i++) begin
        sums_o.grad[i] = mlsc_pkg::sat_add64(sums_q.grad[i], prod_q[i]);
      end
      for (int i = 0; i < 6; i++) begin
        sums_o.hess[i] = mlsc_pkg::sat_add64(sums_q.hess[i], prod_q[3+i]);
      end
    end
    push_o = s1_valid_q & s1_last_q;
    sums_d = sums_q;
    if (s1_valid_q) begin
      sums_d = s1_last_q ? '0 : sums_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s1_use_q   <= 1'b0;
      sums_q     <= '0;
    end else begin
      cnt_q      <= cnt_d;
      s1_valid_q <= accept;
      s1_last_q  <= accept & req_i.last_neighbor;
      s1_use_q   <= accept & (cnt_q < CntW'(MAX_NEIGHBORS));
      sums_q     <= sums_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_q <= prod_d;
    end
  end

endmodule

@@ rtl/mlsc_queue.sv @@
// Two-entry queue of finished sum snapshots between front and back end.
module mlsc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mlsc_pkg::sums_t data_i,
  input  logic            pop_i,
  output logic            valid_o,
  output mlsc_pkg::sums_t data_o,
  output logic [1:0]      free_o
);

  mlsc_pkg::sums_t mem_q [mlsc_pkg::QDepth];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      count_q;

  assign valid_o = count_q != 2'd0;
  assign data_o  = mem_q[rd_ptr_q];
  assign free_o  = 2'(mlsc_pkg::QDepth) - count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/mlsc_finish.sv @@
// Back end: sequencer that turns one set of sums into the curvature result.
module mlsc_finish (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  mlsc_pkg::sums_t data_i,
  input  logic [31:0]     floor_i,
  output logic            pop_o,
  mlsc_res_if.source      res_o
);

  mlsc_pkg::fin_state_e state_q, state_d;
  logic [255:0] x_q, x_d, p_q, p_d, n_q, n_d;
  logic [63:0]  y_q, y_d, m_q, m_d;
  logic [127:0] r_q, r_d, one_q, one_d;
  logic [191:0] den_q, den_d;
  logic [31:0]  q_q, q_d;
  logic [5:0]   cnt_q, cnt_d;
  logic [3:0]   k_q, k_d, nk;
  logic         neg_q, neg_d, big_q, big_d;
  logic         out_valid_q, out_valid_d;
  logic [31:0]  out_curv_q, out_curv_d;
  logic         out_sat_q, out_sat_d;

  logic [63:0]  g_mag [3];
  logic [63:0]  h_mag [6];
  logic [255:0] p_add, n_add, n_abs;
  logic [127:0] tsum;
  logic [63:0]  m_new;
  logic         mul_end;
  mlsc_pkg::term_t ct, nt;

  assign res_o.valid     = out_valid_q;
  assign res_o.curvature = out_curv_q;
  assign res_o.saturated = out_sat_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      g_mag[i] = mlsc_pkg::mag64(data_i.grad[i]);
    end
    for (int i = 0; i < 6; i++) begin
      h_mag[i] = mlsc_pkg::mag64(data_i.hess[i]);
    end
    p_add   = y_q[0] ? p_q + x_q : p_q;
    n_add   = y_q[0] ? (neg_q ? n_q - x_q : n_q + x_q) : n_q;
    n_abs   = n_q[255] ? (~n_q + 256'd1) : n_q;
    tsum    = r_q + one_q;
    m_new   = r_q[63:0] + {32'd0, floor_i};
    mul_end = cnt_q == 6'd63;
    ct      = mlsc_pkg::term_of(k_q);
    nk      = (state_q == mlsc_pkg::FIN_DEN2) ? 4'd0 : k_q + 4'd1;
    nt      = mlsc_pkg::term_of(nk);
  end

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    p_d         = p_q;
    n_d         = n_q;
    y_d         = y_q;
    m_d         = m_q;
    r_d         = r_q;
    one_d       = one_q;
    den_d       = den_q;
    q_d         = q_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    neg_d       = neg_q;
    big_d       = big_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q & ~res_o.ready;
    out_curv_d  = out_curv_q;
    out_sat_d   = out_sat_q;

    unique case (state_q)
      mlsc_pkg::FIN_IDLE: begin
        if (valid_i) begin
          p_d     = '0;
          n_d     = '0;
          x_d     = {192'd0, g_mag[0]};
          y_d     = g_mag[0];
          k_d     = '0;
          cnt_d   = '0;
          state_d = mlsc_pkg::FIN_SQ;
        end
      end
      mlsc_pkg::FIN_SQ: begin
        p_d   = p_add;
        x_d   = x_q << 1;
        y_d   = y_q >> 1;
        cnt_d = cnt_q + 6'd1;
        if (mul_end) begin
          if (k_q == 4'd2) begin
            r_d     = '0;
            one_d   = 128'd1 << 126;
            state_d = mlsc_pkg::FIN_SQRT;
          end else begin
            k_d = k_q + 4'd1;
            x_d = {192'd0, g_mag[k_q[1:0] + 2'd1]};
            y_d = g_mag[k_q[1:0] + 2'd1];
          end
        end
      end
      mlsc_pkg::FIN_SQRT: begin
        if (p_q[127:0] >= tsum) begin
          p_d = {128'd0, p_q[127:0] - tsum};
          r_d = (r_q >> 1) + one_q;
        end else begin
          r_d = r_q >> 1;
        end
        one_d = one_q >> 2;
        cnt_d = cnt_q + 6'd1;
        if (mul_end) begin
          state_d = mlsc_pkg::FIN_MSET;
        end
      end
      mlsc_pkg::FIN_MSET: begin
        m_d   = m_new;
        cnt_d = '0;
        if (m_new == 64'd0) begin
          q_d     = '0;
          big_d   = 1'b0;
          neg_d   = 1'b0;
          state_d = mlsc_pkg::FIN_RES;
        end else begin
          x_d     = {192'd0, m_new};
          y_d     = m_new;
          p_d     = '0;
          state_d = mlsc_pkg::FIN_DEN1;
        end
      end
      mlsc_pkg::FIN_DEN1: begin
        p_d   = p_add;
        x_d   = x_q << 1;
        y_d   = y_q >> 1;
        cnt_d = cnt_q + 6'd1;
        if (mul_end) begin
          x_d     = p_add;
          y_d     = m_q;
          p_d     = '0;
          state_d = mlsc_pkg::FIN_DEN2;
        end
      end
      mlsc_pkg::FIN_DEN2: begin
        p_d   = p_add;
        x_d   = x_q << 1;
        y_d   = y_q >> 1;
        cnt_d = cnt_q + 6'd1;
        if (mul_end) begin
          den_d   = p_add[191:0];
          k_d     = nk;
          x_d     = {192'd0, g_mag[nt.ga]};
          y_d     = g_mag[nt.gb];
          p_d     = '0;
          state_d = mlsc_pkg::FIN_T1;
        end
      end
      mlsc_pkg::FIN_T1: begin
        p_d   = p_add;
        x_d   = x_q << 1;
        y_d   = y_q >> 1;
        cnt_d = cnt_q + 6'd1;
        if (mul_end) begin
          x_d     = ct.dbl ? (p_add << 1) : p_add;
          y_d     = h_mag[ct.hi];
          neg_d   = data_i.grad[ct.ga][63] ^ data_i.grad[ct.gb][63]
                  ^ data_i.hess[ct.hi][63] ^ ct.dbl;
          state_d = mlsc_pkg::FIN_T2;
        end
      end
      mlsc_pkg::FIN_T2: begin
        n_d   = n_add;
        x_d   = x_q << 1;
        y_d   = y_q >> 1;
        cnt_d = cnt_q + 6'd1;
        if (mul_end) begin
          if (k_q == 4'd8) begin
            state_d = mlsc_pkg::FIN_NUMFIX;
          end else begin
            k_d     = nk;
            x_d     = {192'd0, g_mag[nt.ga]};
            y_d     = g_mag[nt.gb];
            p_d     = '0;
            state_d = mlsc_pkg::FIN_T1;
          end
        end
      end
      mlsc_pkg::FIN_NUMFIX: begin
        n_d     = n_abs << 16;
        neg_d   = n_q[255];
        x_d     = {32'd0, den_q, 32'd0};
        state_d = mlsc_pkg::FIN_CHK;
      end
      mlsc_pkg::FIN_CHK: begin
        q_d   = '0;
        cnt_d = '0;
        if (n_q >= x_q) begin
          big_d   = 1'b1;
          state_d = mlsc_pkg::FIN_RES;
        end else begin
          big_d   = 1'b0;
          x_d     = {33'd0, den_q, 31'd0};
          state_d = mlsc_pkg::FIN_DIV;
        end
      end
      mlsc_pkg::FIN_DIV: begin
        if (n_q >= x_q) begin
          n_d = n_q - x_q;
          q_d = {q_q[30:0], 1'b1};
        end else begin
          q_d = {q_q[30:0], 1'b0};
        end
        x_d   = x_q >> 1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          state_d = mlsc_pkg::FIN_RES;
        end
      end
      mlsc_pkg::FIN_RES: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          pop_o       = 1'b1;
          state_d     = mlsc_pkg::FIN_IDLE;
          if (!neg_q) begin
            out_sat_d  = big_q | q_q[31];
            out_curv_d = (big_q | q_q[31]) ? mlsc_pkg::CurvMax : q_q;
          end else if (big_q || q_q > mlsc_pkg::CurvMin) begin
            out_sat_d  = 1'b1;
            out_curv_d = mlsc_pkg::CurvMin;
          end else begin
            out_sat_d  = 1'b0;
            out_curv_d = ~q_q + 32'd1;
          end
        end
      end
      default: state_d = mlsc_pkg::FIN_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mlsc_pkg::FIN_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    p_q        <= p_d;
    n_q        <= n_d;
    y_q        <= y_d;
    m_q        <= m_d;
    r_q        <= r_d;
    one_q      <= one_d;
    den_q      <= den_d;
    q_q        <= q_d;
    neg_q      <= neg_d;
    big_q      <= big_d;
    out_curv_q <= out_curv_d;
    out_sat_q  <= out_sat_d;
  end

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the meshless level-set mean curvature block.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned NbrLimit   = 64;
  localparam int unsigned IdleLimit  = 20000;
  localparam int unsigned DrainWait  = 2000;
  localparam int unsigned RandItems  = 1700;
  localparam logic [2:0]  FloorAddr  = 3'd0;

  // Kinds of row in the directed table.
  typedef enum logic {ROW_NBR, ROW_FLOOR} row_kind_e;

  // One neighbor request as the predictor sees it.
  typedef struct {
    logic signed [31:0] phi_c;
    logic signed [31:0] phi_n;
    logic signed [31:0] wgt [9];
    logic               last;
  } nbr_req_t;

  typedef struct {
    logic [31:0] curv;
    logic        sat;
  } curv_res_t;

  typedef struct {
    row_kind_e   kind;
    nbr_req_t    req;
    logic [31:0] floor_val;
    logic        typed;
    curv_res_t   res;
  } dir_row_t;

  // Numerator terms: gradient a, gradient b, Hessian index, doubled and negated.
  localparam int TermGa [9] = '{0, 0, 1, 0, 0, 2, 1, 1, 2};
  localparam int TermGb [9] = '{0, 1, 1, 0, 2, 2, 1, 2, 2};
  localparam int TermH  [9] = '{1, 3, 0, 2, 4, 0, 2, 5, 1};
  localparam bit TermDb [9] = '{0, 1, 0, 0, 1, 0, 0, 1, 0};

  logic clk_i;
  logic rst_ni;
  logic psel_i, penable_i, pwrite_i;
  logic [2:0] paddr_i;
  logic [31:0] pwdata_i, prdata_o;
  logic pready_o;

  mlsc_req_if req_if ();
  mlsc_res_if res_if ();

  meshless_level_set_curvature #(.MAX_NEIGHBORS(NbrLimit)) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_if.sink),
    .res_o     (res_if.source),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o)
  );

  // Predictor state: its own copy of the floor register and of the sums.
  logic [31:0]   floor_q;
  longint        grad_acc [3];
  longint        hess_acc [6];
  int unsigned   nbr_cnt;
  curv_res_t     curv_q [$];

  int unsigned   errors;
  int unsigned   points_done;
  int unsigned   sat_seen;
  int unsigned   idle_cycles;
  int unsigned   items_sent;
  bit            calm;
  dir_row_t      rows [$];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void note_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
    errors++;
    if (errors <= 10) begin
      $display("mismatch %s: expected %h, got %h", what, exp_v, act_v);
    end
  endfunction

  // Saturating signed 64-bit accumulation.
  function automatic longint acc_sat(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return longint'(s);
  endfunction

  function automatic logic [63:0] abs64(longint v);
    return v < 0 ? 64'(0) - 64'(v) : 64'(v);
  endfunction

  // Closes a point: mean curvature from the current sums.
  function automatic curv_res_t curvature_of_point();
    curv_res_t r;
    logic [129:0] sq, c2;
    logic [63:0]  root, cand, m;
    logic [255:0] pos, neg, num, den, t;
    logic [63:0]  q;
    bit           negative, sgn;
    r.curv = '0;
    r.sat  = 1'b0;
    sq = '0;
    for (int k = 0; k < 3; k++) begin
      sq += 130'(abs64(grad_acc[k])) * 130'(abs64(grad_acc[k]));
    end
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      c2 = 130'(cand) * 130'(cand);
      if (c2 <= sq) root = cand;
    end
    m = root + 64'(floor_q);
    if (m == 0) return r;
    pos = '0;
    neg = '0;
    for (int k = 0; k < 9; k++) begin
      t = 256'(abs64(grad_acc[TermGa[k]]));
      t = t * 256'(abs64(grad_acc[TermGb[k]]));
      t = t * 256'(abs64(hess_acc[TermH[k]]));
      sgn = (grad_acc[TermGa[k]] < 0) ^ (grad_acc[TermGb[k]] < 0) ^
            (hess_acc[TermH[k]] < 0) ^ TermDb[k];
      if (TermDb[k]) t = t << 1;
      if (sgn) neg += t;
      else pos += t;
    end
    negative = pos < neg;
    num = negative ? neg - pos : pos - neg;
    num = num << 16;
    den = 256'(m) * 256'(m) * 256'(m);
    if (num >= (den << 32)) q = 64'hF_FFFF_FFFF;
    else q = 64'(num / den);
    if (!negative && q > 64'h7FFF_FFFF) begin
      q = 64'h7FFF_FFFF;
      r.sat = 1'b1;
    end
    if (negative && q > 64'h8000_0000) begin
      q = 64'h8000_0000;
      r.sat = 1'b1;
    end
    r.curv = negative ? 32'(64'(0) - q) : q[31:0];
    return r;
  endfunction

  // Adds one accepted neighbor into the sums; returns 1 when a point closes.
  function automatic bit absorb_neighbor(nbr_req_t n, output curv_res_t r);
    longint d;
    d = longint'(n.phi_c) - longint'(n.phi_n);
    if (nbr_cnt < NbrLimit) begin
      for (int k = 0; k < 3; k++) grad_acc[k] = acc_sat(grad_acc[k], d * longint'(n.wgt[k]));
      for (int k = 0; k < 6; k++) hess_acc[k] = acc_sat(hess_acc[k], d * longint'(n.wgt[3+k]));
      nbr_cnt++;
    end
    if (!n.last) return 1'b0;
    r = curvature_of_point();
    for (int k = 0; k < 3; k++) grad_acc[k] = 0;
    for (int k = 0; k < 6; k++) hess_acc[k] = 0;
    nbr_cnt = 0;
    return 1'b1;
  endfunction

  // Sender: holds the request until the block takes it, then predicts.
  task automatic send_nbr(nbr_req_t n, bit typed, curv_res_t typed_res);
    curv_res_t r;
    bit closes;
    req_if.valid         <= 1'b1;
    req_if.phi_center    <= n.phi_c;
    req_if.phi_neighbor  <= n.phi_n;
    req_if.weight_dx     <= n.wgt[0];
    req_if.weight_dy     <= n.wgt[1];
    req_if.weight_dz     <= n.wgt[2];
    req_if.weight_dxx    <= n.wgt[3];
    req_if.weight_dyy    <= n.wgt[4];
    req_if.weight_dzz    <= n.wgt[5];
    req_if.weight_dxy    <= n.wgt[6];
    req_if.weight_dxz    <= n.wgt[7];
    req_if.weight_dyz    <= n.wgt[8];
    req_if.last_neighbor <= n.last;
    do @(posedge clk_i); while (!req_if.ready);
    items_sent++;
    closes = absorb_neighbor(n, r);
    if (closes) curv_q.push_back(typed ? typed_res : r);
    // Random gaps between requests, none during the calm stretch.
    if (!calm && $urandom_range(0, 99) < 22) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
  endtask

  // Pauses the sender until every expected curvature has come back.
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (curv_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Register write in setup and access cycles, then a read back of the same register.
  task automatic write_floor(logic [31:0] v);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= FloorAddr;
    pwdata_i  <= v;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    floor_q   = v;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    if (prdata_o !== v) note_mismatch("gradient_floor readback", v, prdata_o);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      3, 4:    return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
      5:       return $urandom() >>> $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  function automatic nbr_req_t make_nbr(logic [31:0] pc, logic [31:0] pn,
                                        logic [31:0] wfill, bit last);
    nbr_req_t n;
    n.phi_c = pc;
    n.phi_n = pn;
    foreach (n.wgt[k]) n.wgt[k] = wfill;
    n.last = last;
    return n;
  endfunction

  function automatic void add_row(nbr_req_t n, bit typed = 1'b0,
                                  logic [31:0] curv = '0, logic sat = 1'b0);
    dir_row_t row;
    row.kind      = ROW_NBR;
    row.req       = n;
    row.floor_val = '0;
    row.typed     = typed;
    row.res.curv  = curv;
    row.res.sat   = sat;
    rows.push_back(row);
  endfunction

  function automatic void add_floor_row(logic [31:0] v);
    dir_row_t row;
    row.kind      = ROW_FLOOR;
    row.floor_val = v;
    row.typed     = 1'b0;
    rows.push_back(row);
  endfunction

  function automatic void build_table();
    nbr_req_t n;
    // An all-zero point right after reset has a zero numerator.
    add_row(make_nbr('0, '0, '0, 1'b1), 1'b1, 32'h0, 1'b0);
    // Gradient alone with no Hessian content still gives zero.
    n = make_nbr(32'h0001_0000, '0, '0, 1'b1);
    n.wgt[0] = 32'h0001_0000;
    add_row(n, 1'b1, 32'h0, 1'b0);
    // Widest difference against extreme weights drives every sum into saturation.
    add_row(make_nbr(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
    add_row(make_nbr(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
    add_row(make_nbr(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1));
    add_row(make_nbr(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    add_row(make_nbr(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
    add_row(make_nbr(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
    // A moderate, well-conditioned point.
    n = make_nbr(32'h0002_0000, 32'h0001_8000, 32'h0000_4000, 1'b0);
    n.wgt[1] = 32'hFFFF_C000;
    add_row(n);
    n = make_nbr(32'h0002_0000, 32'h0003_0000, 32'h0001_0000, 1'b1);
    n.wgt[4] = 32'hFFFE_0000;
    add_row(n);
    // With no floor, a zero gradient gives a zero denominator.
    add_floor_row(32'h0);
    add_row(make_nbr(32'h1234_5678, 32'h1234_5678, 32'h7FFF_FFFF, 1'b1), 1'b1, 32'h0, 1'b0);
    // Unit gradient against a large Hessian clips high, then low.
    n = make_nbr(32'h1, 32'h0, 32'h0, 1'b1);
    n.wgt[0] = 32'h1;
    n.wgt[4] = 32'h7FFF_FFFF;
    add_row(n, 1'b1, 32'h7FFF_FFFF, 1'b1);
    n.wgt[4] = 32'h8000_0000;
    add_row(n, 1'b1, 32'h8000_0000, 1'b1);
    // The largest floor swamps a small gradient.
    add_floor_row(32'hFFFF_FFFF);
    n = make_nbr(32'h0001_0000, 32'h0, 32'h0001_0000, 1'b1);
    add_row(n);
  endfunction

  // One point of random content; now and then it runs past the neighbor limit.
  task automatic send_random_point(output int unsigned count);
    nbr_req_t n;
    logic [31:0] pc;
    int unsigned len;
    len = ($urandom_range(0, 24) == 0) ? $urandom_range(NbrLimit + 1, NbrLimit + 6)
                                       : $urandom_range(1, 8);
    pc = pick_value();
    for (int unsigned i = 0; i < len; i++) begin
      n.phi_c = ($urandom_range(0, 9) == 0) ? pick_value() : pc;
      n.phi_n = pick_value();
      foreach (n.wgt[k]) n.wgt[k] = pick_value();
      n.last = (i == len - 1);
      send_nbr(n, 1'b0, '{default: '0});
    end
    count = len;
  endtask

  // Result side: random back-pressure and comparison in order.
  always @(posedge clk_i or negedge rst_ni) begin
    curv_res_t exp_r;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 25);
      if (res_if.valid && res_if.ready) begin
        points_done++;
        if (curv_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected curvature %h", res_if.curvature);
        end else begin
          exp_r = curv_q.pop_front();
          if (exp_r.sat) sat_seen++;
          if (res_if.curvature !== exp_r.curv) begin
            note_mismatch("curvature", exp_r.curv, res_if.curvature);
          end
          if (res_if.saturated !== exp_r.sat) begin
            note_mismatch("saturated", 32'(exp_r.sat), 32'(res_if.saturated));
          end
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel nor the register port moves.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || psel_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [31:0] floors [4];
    int unsigned cnt, phase_items;
    errors       = 0;
    points_done  = 0;
    sat_seen     = 0;
    idle_cycles  = 0;
    items_sent   = 0;
    calm         = 1'b0;
    floor_q      = mlsc_pkg::FloorReset;
    nbr_cnt      = 0;
    foreach (grad_acc[k]) grad_acc[k] = 0;
    foreach (hess_acc[k]) hess_acc[k] = 0;
    rst_ni       = 1'b0;
    psel_i       = 1'b0;
    penable_i    = 1'b0;
    pwrite_i     = 1'b0;
    paddr_i      = '0;
    pwdata_i     = '0;
    req_if.valid = 1'b0;
    req_if.phi_center    = '0;
    req_if.phi_neighbor  = '0;
    req_if.weight_dx     = '0;
    req_if.weight_dy     = '0;
    req_if.weight_dz     = '0;
    req_if.weight_dxx    = '0;
    req_if.weight_dyy    = '0;
    req_if.weight_dzz    = '0;
    req_if.weight_dxy    = '0;
    req_if.weight_dxz    = '0;
    req_if.weight_dyz    = '0;
    req_if.last_neighbor = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, with register changes between points.
    build_table();
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_FLOOR) begin
        drain();
        write_floor(rows[i].floor_val);
      end else begin
        send_nbr(rows[i].req, rows[i].typed, rows[i].res);
      end
    end

    // Random part over several floor settings; the third one runs without idling.
    floors[0] = mlsc_pkg::FloorReset;
    floors[1] = 32'hFFFF_FFFF;
    floors[2] = $urandom();
    floors[3] = 32'h1;
    for (int p = 0; p < 4; p++) begin
      drain();
      write_floor(floors[p]);
      calm = (p == 2);
      phase_items = 0;
      while (phase_items < RandItems / 4) begin
        send_random_point(cnt);
        phase_items += cnt;
      end
      calm = 1'b0;
    end

    drain();
    repeat (DrainWait) @(posedge clk_i);
    $display("Sent %0d neighbor requests and checked %0d points (%0d clipped),",
             items_sent, points_done, sat_seen);
    $display("over five floor settings including zero and the largest value.");
    if (errors == 0 && curv_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ meshless_level_set_curvature.f @@
rtl/mlsc_pkg.sv
rtl/mlsc_if.sv
rtl/mlsc_accum.sv
rtl/mlsc_queue.sv
rtl/mlsc_finish.sv
rtl/meshless_level_set_curvature.sv
dv/tb.sv
